/* rtl/vfom_pkg.sv */
// Shared types and constants for the vector field occlusion mask block.
// Used by the front end, back end and top level under rtl/; depends on nothing.
package vfom_pkg;

    // Command codes carried by an input beat
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_DRAIN = 2'd2
    } vfom_cmd_e;

    // Configuration register index (byte address bit 2)
    typedef enum logic {
        REG_BLOCKS_X = 1'b0,
        REG_BLOCKS_Y = 1'b1
    } vfom_reg_e;

    localparam int TABLE_DEPTH = 1024;
    localparam int TABLE_AW    = 10;
    localparam int OCC_W       = 10;
    localparam int COL_CAP     = 256;
    localparam int ROW_CAP     = 4096;

    // Queue depths between front and back, and on the result side
    localparam int OP_DEPTH  = 4;
    localparam int OP_LVL_W  = $clog2(OP_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

    // Input beat
    typedef struct packed {
        logic [1:0] command;
        logic [9:0] table_index;
        logic [7:0] table_value;
        logic [7:0] vector_x;
        logic [7:0] vector_y;
    } vfom_item_t;

    // Result beat
    typedef struct packed {
        logic [7:0]  mask_value;
        logic [7:0]  block_x;
        logic [11:0] block_y;
        logic        frame_end;
    } vfom_result_t;

    // Configuration seen by the front end
    typedef struct packed {
        logic [8:0]  blocks_x;
        logic [12:0] blocks_y;
        logic        restart;
    } vfom_cfg_t;

    // Front end stage 1 contents: a table load or a block to evaluate
    typedef struct packed {
        logic        is_load;
        logic [9:0]  load_idx;
        logic [7:0]  load_val;
        logic [7:0]  ex;
        logic [11:0] ey;
        logic        has_left;
        logic        has_right;
        logic        has_top;
        logic        has_bottom;
        logic [7:0]  bottom_y;
        logic [15:0] first;
        logic        frame_end;
    } vfom_emit_t;

    // Operation handed from front to back through the queue
    typedef struct packed {
        logic                is_load;
        logic [TABLE_AW-1:0] addr;
        logic [7:0]          data;
        logic [7:0]          block_x;
        logic [11:0]         block_y;
        logic                frame_end;
    } vfom_op_t;

endpackage

/* rtl/vfom_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module vfom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/vfom_fifo.sv */
// Small register FIFO with fill level; DEPTH must be a power of two.
// Standalone; no package needed.
module vfom_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [LW-1:0]    level_reg;
    logic [LW-1:0]    level_next;

    // Pointer and level update
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        level_next  = level_reg;
        if (wr_en && !rd_en)
        begin
            level_next = level_reg + LW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            level_next = level_reg - LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign level   = level_reg;

endmodule

/* rtl/vfom_front.sv */
// Front end: accepts beats, tracks frame position, keeps the two-row vector
// ring and computes each block's occlusion. Depends on vfom_pkg, vfom_ram.
module vfom_front
    import vfom_pkg::*;
#(
    parameter int MAX_BLOCKS_X = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vfom_cfg_t           cfg,
    input  logic                push,
    output logic                full,
    input  vfom_item_t          item,
    input  logic [OP_LVL_W-1:0] op_level,
    output logic                op_valid,
    output vfom_op_t            op
);

    localparam int AW     = $clog2(2 * MAX_BLOCKS_X);
    localparam int BX_CAP = (MAX_BLOCKS_X < COL_CAP) ? MAX_BLOCKS_X : COL_CAP;

    // Ring slot: row parity selects the half, column indexes within it
    function automatic logic [AW-1:0] slot_addr(input logic parity, input logic [7:0] col);
        logic [AW-1:0] base;
        base = parity ? AW'(MAX_BLOCKS_X) : '0;
        return base + AW'(col);
    endfunction

    logic [8:0]  bx_eff;
    logic [12:0] by_eff;
    logic [7:0]  bx_last;
    logic [11:0] by_last;

    logic        accept;
    logic        do_load;
    logic        do_push;
    logic        do_drain;
    logic        emit;
    logic        emit_end;

    // Push and emission position
    logic [7:0]  pc_reg, pc_next;
    logic [11:0] pr_reg, pr_next;
    logic        push_done_reg, push_done_next;
    logic [7:0]  ec_reg, ec_next;
    logic [11:0] er_reg, er_next;
    logic [15:0] first_reg, first_next;

    logic [AW-1:0] ring_waddr;
    logic [15:0]   ring_wdata;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rd_b_addr;
    logic [15:0]   rd_a;
    logic [15:0]   rd_b;
    logic [7:0]    right_col;

    vfom_emit_t  s1_reg, s1_next;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [15:0] last_a_reg;
    logic [15:0] last_cur_reg;

    logic [15:0] cur_vec;
    logic [7:0]  cur_x, cur_y, left_x, right_x, top_y;
    logic [7:0]  d_left, d_right, d_top, d_bot;
    logic [OCC_W-1:0] occ;
    logic [OP_LVL_W:0] in_flight;

    // Effective frame size from the raw registers
    always_comb
    begin
        bx_eff = cfg.blocks_x;
        if (bx_eff == 9'd0)
        begin
            bx_eff = 9'd1;
        end
        if (bx_eff > 9'(BX_CAP))
        begin
            bx_eff = 9'(BX_CAP);
        end
        by_eff = cfg.blocks_y;
        if (by_eff == 13'd0)
        begin
            by_eff = 13'd1;
        end
        if (by_eff > 13'(ROW_CAP))
        begin
            by_eff = 13'(ROW_CAP);
        end
        bx_last = 8'(bx_eff - 9'd1);
        by_last = 12'(by_eff - 13'd1);
    end

    // Credit check: queue entries plus the one beat in stage 1
    assign in_flight = (OP_LVL_W + 1)'(op_level) + (OP_LVL_W + 1)'(s1_valid_reg);
    assign full      = in_flight >= (OP_LVL_W + 1)'(OP_DEPTH);
    assign accept    = push && !full;

    // Classify the beat
    always_comb
    begin
        do_load  = 1'b0;
        do_push  = 1'b0;
        do_drain = 1'b0;
        case (vfom_cmd_e'(item.command))
            CMD_LOAD:  do_load  = accept;
            CMD_PUSH:  do_push  = accept && !push_done_reg;
            CMD_DRAIN: do_drain = accept && push_done_reg;
            default:   ;
        endcase
        emit     = (do_push && (pr_reg != 12'd0)) || do_drain;
        emit_end = (er_reg == by_last) && (ec_reg == bx_last);
    end

    // Ring access: write the new vector, read right neighbor and top row
    always_comb
    begin
        right_col  = (ec_reg == bx_last) ? ec_reg : ec_reg + 8'd1;
        ring_waddr = slot_addr(pr_reg[0], pc_reg);
        ring_wdata = {item.vector_y, item.vector_x};
        rd_a_addr  = slot_addr(er_reg[0], right_col);
        rd_b_addr  = slot_addr(!er_reg[0], ec_reg);
    end

    vfom_ram #(
        .WIDTH(16),
        .DEPTH(2 * MAX_BLOCKS_X)
    ) u_ring_a (
        .clk  (clk),
        .we   (do_push),
        .waddr(ring_waddr),
        .wdata(ring_wdata),
        .raddr(rd_a_addr),
        .rdata(rd_a)
    );

    vfom_ram #(
        .WIDTH(16),
        .DEPTH(2 * MAX_BLOCKS_X)
    ) u_ring_b (
        .clk  (clk),
        .we   (do_push),
        .waddr(ring_waddr),
        .wdata(ring_wdata),
        .raddr(rd_b_addr),
        .rdata(rd_b)
    );

    // Frame position counters
    always_comb
    begin
        pc_next        = pc_reg;
        pr_next        = pr_reg;
        push_done_next = push_done_reg;
        ec_next        = ec_reg;
        er_next        = er_reg;
        first_next     = first_reg;
        if (do_push)
        begin
            if (pc_reg == 8'd0)
            begin
                first_next = ring_wdata;
            end
            if (pc_reg == bx_last)
            begin
                pc_next = 8'd0;
                if (pr_reg == by_last)
                begin
                    push_done_next = 1'b1;
                end
                else
                begin
                    pr_next = pr_reg + 12'd1;
                end
            end
            else
            begin
                pc_next = pc_reg + 8'd1;
            end
        end
        if (emit)
        begin
            if (ec_reg == bx_last)
            begin
                ec_next = 8'd0;
                er_next = er_reg + 12'd1;
            end
            else
            begin
                ec_next = ec_reg + 8'd1;
            end
        end
        // Frame done or register rewrite: start over
        if ((emit && emit_end) || cfg.restart)
        begin
            pc_next        = 8'd0;
            pr_next        = 12'd0;
            push_done_next = 1'b0;
            ec_next        = 8'd0;
            er_next        = 12'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            pr_reg        <= '0;
            push_done_reg <= 1'b0;
            ec_reg        <= '0;
            er_reg        <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            pr_reg        <= pr_next;
            push_done_reg <= push_done_next;
            ec_reg        <= ec_next;
            er_reg        <= er_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    // Stage 1 contents
    always_comb
    begin
        s1_valid_next       = do_load || emit;
        s1_next.is_load     = do_load;
        s1_next.load_idx    = item.table_index;
        s1_next.load_val    = item.table_value;
        s1_next.ex          = ec_reg;
        s1_next.ey          = er_reg;
        s1_next.has_left    = ec_reg != 8'd0;
        s1_next.has_right   = ec_reg != bx_last;
        s1_next.has_top     = er_reg != 12'd0;
        s1_next.has_bottom  = do_push;
        s1_next.bottom_y    = item.vector_y;
        s1_next.first       = first_reg;
        s1_next.frame_end   = emit_end;
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        s1_reg    <= s1_next;
        // Sliding window along the row: keep this block and its right neighbor
        if (s1_valid_reg && !s1_reg.is_load)
        begin
            last_a_reg   <= rd_a;
            last_cur_reg <= cur_vec;
        end
    end

    // Occlusion: sum of positive neighbor differences
    always_comb
    begin
        cur_vec = s1_reg.has_left ? last_a_reg : s1_reg.first;
        cur_x   = cur_vec[7:0];
        cur_y   = cur_vec[15:8];
        left_x  = last_cur_reg[7:0];
        right_x = rd_a[7:0];
        top_y   = rd_b[15:8];
        d_left  = (s1_reg.has_left && left_x > cur_x) ? left_x - cur_x : 8'd0;
        d_right = (s1_reg.has_right && cur_x > right_x) ? cur_x - right_x : 8'd0;
        d_top   = (s1_reg.has_top && top_y > cur_y) ? top_y - cur_y : 8'd0;
        d_bot   = (s1_reg.has_bottom && cur_y > s1_reg.bottom_y) ?
                  cur_y - s1_reg.bottom_y : 8'd0;
        occ     = OCC_W'(d_left) + OCC_W'(d_right) + OCC_W'(d_top) + OCC_W'(d_bot);
    end

    // Operation to the back end
    always_comb
    begin
        op_valid     = s1_valid_reg;
        op.is_load   = s1_reg.is_load;
        op.addr      = s1_reg.is_load ? s1_reg.load_idx : TABLE_AW'(occ);
        op.data      = s1_reg.load_val;
        op.block_x   = s1_reg.ex;
        op.block_y   = s1_reg.ey;
        op.frame_end = s1_reg.frame_end;
    end

endmodule

/* rtl/vfom_back.sv */
// Back end: applies table loads and looks up mask bytes for queued blocks.
// Depends on vfom_pkg, vfom_ram.
module vfom_back
    import vfom_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  vfom_op_t             head,
    output logic                 head_pop,
    input  logic [OUT_LVL_W-1:0] res_level,
    output logic                 res_valid,
    output vfom_result_t         res
);

    logic              tbl_we;
    logic [7:0]        tbl_rdata;
    logic [OUT_LVL_W:0] out_used;
    logic              b1_valid_reg;
    logic              b1_valid_next;
    vfom_op_t          b1_reg;

    // Loads always go; lookups need room in the result queue
    assign out_used = (OUT_LVL_W + 1)'(res_level) + (OUT_LVL_W + 1)'(b1_valid_reg);
    assign head_pop = head_valid &&
                      (head.is_load || (out_used < (OUT_LVL_W + 1)'(OUT_DEPTH)));
    assign tbl_we        = head_pop && head.is_load;
    assign b1_valid_next = head_pop && !head.is_load;

    vfom_ram #(
        .WIDTH(8),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (tbl_we),
        .waddr(head.addr),
        .wdata(head.data),
        .raddr(head.addr),
        .rdata(tbl_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= b1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_reg <= head;
    end

    // Result beat
    always_comb
    begin
        res_valid      = b1_valid_reg;
        res.mask_value = tbl_rdata;
        res.block_x    = b1_reg.block_x;
        res.block_y    = b1_reg.block_y;
        res.frame_end  = b1_reg.frame_end;
    end

endmodule

/* rtl/vector_field_occlusion_mask.sv */
// Top level of the vector field occlusion mask: config registers, front end,
// op queue, back end and result queue. Depends on vfom_pkg and all rtl/ modules.
//
// Usage:
//   Input side is a queue: drive item and push; the beat is taken when full
//   is low. Commands: load a response table byte, push the next block vector
//   of the raster, or drain one pending result after the frame is pushed.
//   Result side is a queue: a result is shown while empty is low and taken
//   with pop. The result for a block comes out when the block below it is
//   pushed (one row of lag); the last row comes out on drain beats.
//   One beat per cycle is accepted sustained while full is low. A beat passes
//   the front stage with ring RAM read, op queue write, table RAM read and
//   result queue write in that order. Table loads stay in order with lookups
//   because both go through the same op queue to the back end.
//   When pop is held low, the result queue and then the op queue fill and
//   full rises; no beat is lost. Reset empties both queues, zeroes the frame
//   position and sets blocks_x and blocks_y to 1; ring and table contents
//   are undefined until written. Writing either register restarts the frame.
//   APB port: blocks_x at 0x0, blocks_y at 0x4; write only while idle.
module vector_field_occlusion_mask
    import vfom_pkg::*;
#(
    parameter int MAX_BLOCKS_X = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         push,
    output logic         full,
    input  vfom_item_t   item,
    output logic         empty,
    input  logic         pop,
    output vfom_result_t result
);

    logic [8:0]  blocks_x_reg, blocks_x_next;
    logic [12:0] blocks_y_reg, blocks_y_next;
    logic        cfg_write;
    vfom_cfg_t   cfg;

    logic                 op_valid;
    vfom_op_t             op;
    vfom_op_t             op_head;
    logic [OP_LVL_W-1:0]  op_level;
    logic                 op_pop;
    logic                 res_valid;
    vfom_result_t         res;
    logic [OUT_LVL_W-1:0] res_level;
    logic                 res_pop;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        blocks_x_next = blocks_x_reg;
        blocks_y_next = blocks_y_reg;
        if (cfg_write)
        begin
            case (vfom_reg_e'(paddr[2]))
                REG_BLOCKS_X: blocks_x_next = pwdata[8:0];
                REG_BLOCKS_Y: blocks_y_next = pwdata[12:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_x_reg <= 9'd1;
            blocks_y_reg <= 13'd1;
        end
        else
        begin
            blocks_x_reg <= blocks_x_next;
            blocks_y_reg <= blocks_y_next;
        end
    end

    always_comb
    begin
        case (vfom_reg_e'(paddr[2]))
            REG_BLOCKS_X: prdata = 32'(blocks_x_reg);
            REG_BLOCKS_Y: prdata = 32'(blocks_y_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.blocks_x = blocks_x_reg;
    assign cfg.blocks_y = blocks_y_reg;
    assign cfg.restart  = cfg_write;

    // Front end
    vfom_front #(
        .MAX_BLOCKS_X(MAX_BLOCKS_X)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .push    (push),
        .full    (full),
        .item    (item),
        .op_level(op_level),
        .op_valid(op_valid),
        .op      (op)
    );

    // Queue between front and back
    vfom_fifo #(
        .WIDTH($bits(vfom_op_t)),
        .DEPTH(OP_DEPTH)
    ) u_op_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (op_valid),
        .wr_data(op),
        .rd_en  (op_pop),
        .rd_data(op_head),
        .level  (op_level)
    );

    // Back end
    vfom_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(op_level != '0),
        .head      (op_head),
        .head_pop  (op_pop),
        .res_level (res_level),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result queue
    assign empty   = res_level == '0;
    assign res_pop = pop && !empty;

    vfom_fifo #(
        .WIDTH($bits(vfom_result_t)),
        .DEPTH(OUT_DEPTH)
    ) u_res_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_valid),
        .wr_data(res),
        .rd_en  (res_pop),
        .rd_data(result),
        .level  (res_level)
    );

    // Credit accounting never overruns either queue
    a_op_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid |-> (op_level < OP_LVL_W'(OP_DEPTH)))
        else $error("op queue written while full");

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_level < OUT_LVL_W'(OUT_DEPTH)))
        else $error("result queue written while full");

    // Every op comes from a beat accepted the cycle before
    a_op_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid |-> $past(push && !full))
        else $error("op without an accepted input beat");

endmodule
